// ----- hw/rtl/stq_pkg.sv -----
// Shared types and codes for the sorted task ready queue.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    CMD_SORTED = 2'd0,
    CMD_FRONT  = 2'd1,
    CMD_BACK   = 2'd2,
    CMD_POP    = 2'd3
  } stq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stq_status_t;

  localparam logic [1:0] KEY_ARRIVAL = 2'd0;
  localparam logic [1:0] KEY_BURST   = 2'd1;
  localparam logic [1:0] KEY_PRIO    = 2'd2;
  localparam logic [1:0] KEY_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [15:0] remaining_burst;
    logic [7:0]  prio_level;
  } stq_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       out_id;
    logic [15:0]      out_arrival;
    logic [15:0]      out_burst;
    logic [7:0]       out_prio;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
  } stq_out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } stq_entry_t;

  localparam int ENTRY_W = $bits(stq_entry_t);

endpackage

`default_nettype wire

// ----- hw/rtl/stq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/stq_cmp.sv -----
// Shared key compare unit: does the new entry pass the held entry.
`timescale 1ns / 1ps
`default_nettype none

module stq_cmp (
  input  wire logic [1:0]          sort_key,
  input  wire stq_pkg::stq_entry_t new_ent,
  input  wire stq_pkg::stq_entry_t held_ent,
  output logic                     passes
);
  import stq_pkg::*;

  logic [15:0] key_new;
  logic [15:0] key_held;

  always_comb begin
    case (sort_key)
      KEY_ARRIVAL: begin
        key_new  = new_ent.arrival;
        key_held = held_ent.arrival;
      end
      KEY_BURST: begin
        key_new  = new_ent.burst;
        key_held = held_ent.burst;
      end
      default: begin
        key_new  = {8'd0, new_ent.prio};
        key_held = {8'd0, held_ent.prio};
      end
    endcase
  end

  always_comb begin
    if (sort_key == KEY_NONE) begin
      passes = 1'b0;
    end else if (key_new == key_held) begin
      passes = new_ent.id > held_ent.id;
    end else begin
      passes = key_new > key_held;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_task_ready_queue.sv -----
// Top level: sorted task ready queue with its command sequencer.
//
// Usage: drive in_data and raise start; the command word is taken at a
// rising edge where start is high and busy is low. busy then stays high
// until the result is issued. The result word appears on out_data for
// exactly one cycle with out_valid high; the receiver cannot stall it.
// sort_key is written through cfg_we/cfg_wdata; the user must write it
// only while the queue is idle; the block itself does not enforce this.
// Entries live in one RAM with a registered read port, and one compare
// unit is reused for every step of the search. Push back writes the
// entry at the tail; push front and insert with key none shift every
// held entry up one place and write at the head; a sorted insert first
// searches from the head for the first entry that the new one does not
// pass, then shifts the rest up; a pop reads the head and shifts the
// rest down. Full inserts and pops on empty skip the RAM entirely.
// Reset empties the queue and clears sort_key to arrival time; RAM
// contents are not cleared, as only held entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_task_ready_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire stq_pkg::stq_in_t in_data,
  output logic                  out_valid,
  output stq_pkg::stq_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_wdata
);
  import stq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SRCH_RD  = 10'b00_0000_0010,
    S_SRCH_CMP = 10'b00_0000_0100,
    S_UP_CHK   = 10'b00_0000_1000,
    S_MOVE_RD  = 10'b00_0001_0000,
    S_MOVE_WR  = 10'b00_0010_0000,
    S_PLACE    = 10'b00_0100_0000,
    S_POP_RD   = 10'b00_1000_0000,
    S_POP_CAP  = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } stq_state_t;

  stq_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          up_r, up_nxt;
  logic [1:0]    status_r, status_nxt;
  stq_entry_t    ent_r, ent_nxt;
  stq_entry_t    pop_r, pop_nxt;
  logic          out_valid_r, out_valid_nxt;
  stq_out_t      out_r, out_nxt;
  logic [1:0]    sort_key_r;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  stq_entry_t    ram_wdata, rd_ent;
  logic          pass;
  logic          full;

  stq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_ent)
  );

  stq_cmp u_cmp (
    .sort_key(sort_key_r),
    .new_ent (ent_r),
    .held_ent(rd_ent),
    .passes  (pass)
  );

  assign full = (count_r == CW'(QUEUE_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    up_nxt        = up_r;
    status_nxt    = status_r;
    ent_nxt       = ent_r;
    pop_nxt       = pop_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_r;
    ram_raddr     = idx_r;
    ram_wdata     = rd_ent;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ent_nxt.id      = in_data.task_id;
          ent_nxt.arrival = in_data.arrival;
          ent_nxt.burst   = in_data.remaining_burst;
          ent_nxt.prio    = in_data.prio_level;
          pop_nxt         = '0;
          status_nxt      = ST_OK;
          pos_nxt         = '0;
          up_nxt          = 1'b1;
          if (in_data.cmd == CMD_POP) begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_POP_RD;
            end
          end else if (full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else if (in_data.cmd == CMD_BACK) begin
            pos_nxt   = IW'(count_r);
            state_nxt = S_PLACE;
          end else if (in_data.cmd == CMD_FRONT || sort_key_r == KEY_NONE) begin
            state_nxt = S_UP_CHK;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (CW'(pos_r) == count_r) begin
          state_nxt = S_UP_CHK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pos_r;
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (pass) begin
          pos_nxt   = pos_r + IW'(1);
          state_nxt = S_SRCH_RD;
        end else begin
          state_nxt = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        idx_nxt = IW'(count_r - CW'(1));
        if (CW'(pos_r) == count_r) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rd_ent;
        if (up_r) begin
          ram_waddr = idx_r + IW'(1);
          if (idx_r == pos_r) begin
            state_nxt = S_PLACE;
          end else begin
            idx_nxt   = idx_r - IW'(1);
            state_nxt = S_MOVE_RD;
          end
        end else begin
          ram_waddr = idx_r - IW'(1);
          if (CW'(idx_r) + CW'(1) == count_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_MOVE_RD;
          end
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = ent_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end
      S_POP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = S_POP_CAP;
      end
      S_POP_CAP: begin
        pop_nxt = rd_ent;
        up_nxt  = 1'b0;
        idx_nxt = IW'(1);
        if (count_r == CW'(1)) begin
          count_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_RESP: begin
        out_valid_nxt        = 1'b1;
        out_nxt.status       = status_r;
        out_nxt.out_id       = pop_r.id;
        out_nxt.out_arrival  = pop_r.arrival;
        out_nxt.out_burst    = pop_r.burst;
        out_nxt.out_prio     = pop_r.prio;
        out_nxt.occupancy    = OCC_W'(count_r);
        out_nxt.is_empty     = (count_r == '0);
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sort_key_r  <= KEY_ARRIVAL;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        sort_key_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    up_r     <= up_nxt;
    status_r <= status_nxt;
    ent_r    <= ent_nxt;
    pop_r    <= pop_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_strobe_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_RESP))
    else $error("result strobe without response step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_FULL) |->
      (out_r.occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full rejection with wrong occupancy");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PLACE && state_r != S_MOVE_WR && state_r != S_POP_CAP) |=>
      $stable(count_r))
    else $error("entry count changed outside an update step");

endmodule

`default_nettype wire
